### rtl/pip_pkg.sv
// shared types and constants for the point-in-polygon test
`timescale 1ns / 1ps
package pip_pkg;

	// default vertex table depth
	localparam int MAX_VERTICES_DEF = 64;

	// fixed field widths
	localparam int COORD_W = 16;
	localparam int IDX_W   = 6;
	localparam int CNT_W   = 7;
	localparam int VTX_W   = 2 * COORD_W;

	// mode field codes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TEST = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_point;
		logic clear_parity;
		logic wr_en;
		logic rd_en;
		logic rd_prime;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pending;
	} sts_t;

endpackage

### rtl/point_in_polygon_test.sv
// top level of the even-odd point-in-polygon test
// an item is taken when start is high and busy is low. with mode low the beat writes
// one vertex (x in the low half, y in the high half) into the table slot vertex_index
// in that same cycle; busy stays low, so a load can follow in every cycle, and a slot at
// or beyond MaxVertices is dropped. with mode high the beat is a query point: busy rises,
// the controller reads vertex n-1 and then vertices 0 to n-1 through the table's single
// read port, one edge per cycle, and the result appears on inside_res with done high for
// exactly one cycle once the last edge has drained from the edge test pipeline, where n
// is vertex_count clamped to MaxVertices. busy drops with the result and the next item
// may be taken in the cycle after it. the receiver cannot stall: a result not taken in
// its strobe cycle is lost. vertex_count is written over its own valid/ready channel,
// ready only while idle; every slot below the count must have been loaded before a query
`timescale 1ns / 1ps
module point_in_polygon_test #(
	parameter int MaxVertices = pip_pkg::MAX_VERTICES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// item channel
	input  logic                               start,
	output logic                               busy,
	input  logic                               mode,
	input  logic [pip_pkg::IDX_W-1:0]          vertex_index,
	input  logic signed [pip_pkg::COORD_W-1:0] coord_x,
	input  logic signed [pip_pkg::COORD_W-1:0] coord_y,
	// configuration channel, vertex_count
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pip_pkg::CNT_W-1:0]          cfg_data,
	// result strobe
	output logic                               done,
	output logic                               inside_res
);

	pip_pkg::cmd_t                  cmd;
	pip_pkg::sts_t                  sts;
	logic [$clog2(MaxVertices)-1:0] rd_addr;

	// sequencer: accepts beats, holds the count, walks the edge list
	pip_ctrl #(
		.MaxVertices(MaxVertices)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.vertex_index(vertex_index),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.sts         (sts),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.done        (done)
	);

	// vertex table, two-stage edge test (differences and products, then compare), parity
	pip_dp #(
		.MaxVertices(MaxVertices)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.rd_addr     (rd_addr),
		.vertex_index(vertex_index),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.inside_res  (inside_res)
	);

endmodule

### rtl/pip_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module pip_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/pip_ctrl.sv
// controller for the point-in-polygon test: handshake, count register, edge walk
`timescale 1ns / 1ps
module pip_ctrl #(
	parameter int MaxVertices = pip_pkg::MAX_VERTICES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               mode,
	input  logic [pip_pkg::IDX_W-1:0]          vertex_index,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pip_pkg::CNT_W-1:0]          cfg_data,
	input  pip_pkg::sts_t                      sts,
	output pip_pkg::cmd_t                      cmd,
	output logic [$clog2(MaxVertices)-1:0]     rd_addr,
	output logic                               done
);

	localparam int AW    = $clog2(MaxVertices);
	localparam int CW    = $clog2(MaxVertices + 1);
	localparam int CmpW  = CW + pip_pkg::CNT_W;
	localparam int SlotW = pip_pkg::IDX_W + AW;

	pip_pkg::state_t state_q, state_d;

	logic [pip_pkg::CNT_W-1:0] vertex_count_q;
	logic [CW-1:0]             n_q;
	logic [AW-1:0]             idx_q;
	logic [CW-1:0]             n_eff;
	logic [CW-1:0]             n_last;
	logic [SlotW-1:0]          slot_ext;
	logic                      slot_ok;
	logic                      accept;
	logic                      accept_test;
	logic                      walk_last;

	// clamp the count to the table depth
	assign n_eff = (CmpW'(vertex_count_q) > CmpW'(MaxVertices))
	               ? CW'(MaxVertices) : CW'(vertex_count_q);
	assign n_last    = n_q - CW'(1);
	assign slot_ext  = SlotW'(vertex_index);
	assign slot_ok   = slot_ext < SlotW'(MaxVertices);
	assign accept    = start && (state_q == pip_pkg::ST_IDLE);
	assign accept_test = accept && (mode == pip_pkg::MODE_TEST);
	assign walk_last = (CW'(idx_q) + CW'(1)) == n_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pip_pkg::ST_IDLE: begin
				if (accept_test) begin
					state_d = (n_eff == '0) ? pip_pkg::ST_DRAIN : pip_pkg::ST_PRIME;
				end
			end
			pip_pkg::ST_PRIME: state_d = pip_pkg::ST_WALK;
			pip_pkg::ST_WALK: begin
				if (walk_last) begin
					state_d = pip_pkg::ST_DRAIN;
				end
			end
			pip_pkg::ST_DRAIN: begin
				if (!sts.pending) begin
					state_d = pip_pkg::ST_DONE;
				end
			end
			pip_pkg::ST_DONE: state_d = pip_pkg::ST_IDLE;
			default: state_d = pip_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load_point   = accept_test;
		cmd.clear_parity = accept_test;
		cmd.wr_en        = accept && (mode == pip_pkg::MODE_LOAD) && slot_ok;
		cmd.rd_en        = 1'b0;
		cmd.rd_prime     = 1'b0;
		rd_addr          = idx_q;
		case (state_q)
			pip_pkg::ST_PRIME: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_prime = 1'b1;
				rd_addr      = n_last[AW-1:0];
			end
			pip_pkg::ST_WALK: begin
				cmd.rd_en = 1'b1;
			end
			default: begin
				cmd.rd_en = 1'b0;
			end
		endcase
	end

	assign busy      = (state_q != pip_pkg::ST_IDLE);
	assign cfg_ready = (state_q == pip_pkg::ST_IDLE);
	assign done      = (state_q == pip_pkg::ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= pip_pkg::ST_IDLE;
			vertex_count_q <= '0;
			n_q            <= '0;
			idx_q          <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				vertex_count_q <= cfg_data;
			end
			if (accept_test) begin
				n_q   <= n_eff;
				idx_q <= '0;
			end else if (state_q == pip_pkg::ST_WALK) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

endmodule

### rtl/pip_dp.sv
// datapath for the point-in-polygon test: vertex table, edge test, parity
`timescale 1ns / 1ps
module pip_dp #(
	parameter int MaxVertices = pip_pkg::MAX_VERTICES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pip_pkg::cmd_t                         cmd,
	output pip_pkg::sts_t                         sts,
	input  logic [$clog2(MaxVertices)-1:0]        rd_addr,
	input  logic [pip_pkg::IDX_W-1:0]             vertex_index,
	input  logic signed [pip_pkg::COORD_W-1:0]    coord_x,
	input  logic signed [pip_pkg::COORD_W-1:0]    coord_y,
	output logic                                  inside_res
);

	localparam int AW  = $clog2(MaxVertices);
	localparam int CWD = pip_pkg::COORD_W;
	localparam int DW  = CWD + 1;
	localparam int PW  = 2 * DW;

	logic [pip_pkg::IDX_W+AW-1:0] idx_ext;
	logic [pip_pkg::VTX_W-1:0]    rdata;

	logic signed [CWD-1:0] px_q, py_q;
	logic signed [CWD-1:0] xj_q, yj_q;
	logic                  valid_s1, prime_s1;
	logic                  valid_s2, act_s2, dypos_s2;
	logic signed [PW-1:0]  lhs_s2, rhs_s2;
	logic                  parity_q;

	logic signed [CWD-1:0] xi, yi;
	logic signed [DW-1:0]  dy, dxj, dyp, dxp;
	logic                  straddle, leftish, crosses;

	assign idx_ext = {{AW{1'b0}}, vertex_index};

	pip_ram #(
		.Width(pip_pkg::VTX_W),
		.Depth(MaxVertices)
	) u_vtx_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(idx_ext[AW-1:0]),
		.wdata({coord_y, coord_x}),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// edge from previous vertex j to current vertex i
	assign xi  = $signed(rdata[CWD-1:0]);
	assign yi  = $signed(rdata[2*CWD-1:CWD]);
	assign dy  = $signed({yj_q[CWD-1], yj_q}) - $signed({yi[CWD-1], yi});
	assign dxj = $signed({xj_q[CWD-1], xj_q}) - $signed({xi[CWD-1], xi});
	assign dyp = $signed({py_q[CWD-1], py_q}) - $signed({yi[CWD-1], yi});
	assign dxp = $signed({px_q[CWD-1], px_q}) - $signed({xi[CWD-1], xi});

	assign straddle = ((yi < py_q) && (yj_q >= py_q)) || ((yj_q < py_q) && (yi >= py_q));
	assign leftish  = (xi <= px_q) || (xj_q <= px_q);

	// sign-corrected cross-multiplied abscissa compare
	assign crosses = dypos_s2 ? (lhs_s2 < rhs_s2) : (lhs_s2 > rhs_s2);

	assign sts.pending = valid_s1 || valid_s2;
	assign inside_res  = parity_q;

	always_ff @(posedge clk) begin
		if (cmd.load_point) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if (valid_s1) begin
			xj_q <= xi;
			yj_q <= yi;
		end
		lhs_s2   <= dyp * dxj;
		rhs_s2   <= dxp * dy;
		dypos_s2 <= (dy > 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			prime_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			act_s2   <= 1'b0;
			parity_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			prime_s1 <= cmd.rd_prime;
			valid_s2 <= valid_s1;
			act_s2   <= valid_s1 && !prime_s1 && straddle && leftish;
			if (cmd.clear_parity) begin
				parity_q <= 1'b0;
			end else if (valid_s2 && act_s2 && crosses) begin
				parity_q <= !parity_q;
			end
		end
	end

endmodule

### rtl/pip_checker.sv
// port-level checker for the point-in-polygon test, bound to the top level
`timescale 1ns / 1ps
module pip_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic mode,
	input logic done
);

	// result strobe lasts a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// a result only closes a query in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// a query beat makes the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode) |=> busy)
		else $error("query accepted without busy");

	// a vertex load completes in its accepting cycle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !mode) |=> (!busy && !done))
		else $error("vertex load left the block busy");

	// busy only ends through a result
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !done) |=> busy)
		else $error("busy dropped without a result");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.mode  (mode),
	.done  (done)
);
